[hdl/utf8_char_packer_macros.svh]
// assertion helpers for the checker file
`ifndef UTF8_CHAR_PACKER_MACROS_SVH
`define UTF8_CHAR_PACKER_MACROS_SVH

// same-cycle implication, quiet during reset
`define U8CP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define U8CP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/u8cp_pkg.sv]
package u8cp_pkg;

  localparam logic [31:0] FFFD_PACKED = 32'h00BDBFEF;
  localparam logic [2:0]  FFFD_LEN    = 3'd3;
  localparam logic [2:0]  TERM_LEN    = 3'd0;

  // lead byte classes, value equals the announced length
  localparam logic [2:0] CLASS_BAD   = 3'd0;
  localparam logic [2:0] CLASS_ASCII = 3'd1;
  localparam logic [2:0] CLASS_TWO   = 3'd2;
  localparam logic [2:0] CLASS_THREE = 3'd3;
  localparam logic [2:0] CLASS_FOUR  = 3'd4;

  // results caused by one item: some replacement chars, then an optional tail
  typedef struct packed {
    logic [1:0]  fffd_cnt;
    logic        tail_vld;
    logic [31:0] tail_packed;
    logic [2:0]  tail_len;
  } burst_t;

  function automatic logic [2:0] lead_class(input logic [7:0] b);
    logic [2:0] c;
    if ((b & 8'h80) == 8'h00)      c = CLASS_ASCII;
    else if ((b & 8'hE0) == 8'hC0) c = CLASS_TWO;
    else if ((b & 8'hF0) == 8'hE0) c = CLASS_THREE;
    else if ((b & 8'hF8) == 8'hF0) c = CLASS_FOUR;
    else                           c = CLASS_BAD;
    return c;
  endfunction

endpackage

[hdl/u8cp_decode.sv]
module u8cp_decode
  import u8cp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] byte_in,
  output burst_t     burst
);

  logic [7:0] held_bytes [3];
  logic [2:0] expected_length;
  logic [1:0] held_count;

  logic [2:0] expected_length_next;
  logic [1:0] held_count_next;
  logic       hold_lead;
  logic       store_cont;
  logic       run_fresh;
  logic       is_cont;
  logic [2:0] cls;

  assign is_cont = (byte_in & 8'hC0) == 8'h80;
  assign cls     = lead_class(byte_in);

  always_comb begin
    burst                = '0;
    hold_lead            = 1'b0;
    store_cont           = 1'b0;
    run_fresh            = 1'b0;
    held_count_next      = 2'd0;
    expected_length_next = 3'd0;

    if (held_count == 2'd0) begin
      run_fresh = 1'b1;
    end else if (is_cont) begin
      if ({1'b0, held_count} + 3'd1 >= expected_length) begin
        burst.tail_vld = 1'b1;
        burst.tail_len = {1'b0, held_count} + 3'd1;
        case (held_count)
          2'd1:    burst.tail_packed = {16'h0, byte_in, held_bytes[0]};
          2'd2:    burst.tail_packed = {8'h0, byte_in, held_bytes[1], held_bytes[0]};
          default: burst.tail_packed = {byte_in, held_bytes[2], held_bytes[1],
                                        held_bytes[0]};
        endcase
      end else begin
        store_cont           = 1'b1;
        held_count_next      = held_count + 2'd1;
        expected_length_next = expected_length;
      end
    end else begin
      // broken sequence: one replacement per held byte, then start over
      burst.fffd_cnt = held_count;
      run_fresh      = 1'b1;
    end

    if (run_fresh) begin
      if (byte_in == 8'h00) begin
        burst.tail_vld    = 1'b1;
        burst.tail_packed = 32'h0;
        burst.tail_len    = TERM_LEN;
      end else if (cls == CLASS_ASCII) begin
        burst.tail_vld    = 1'b1;
        burst.tail_packed = {24'h0, byte_in};
        burst.tail_len    = CLASS_ASCII;
      end else if (cls == CLASS_BAD) begin
        burst.tail_vld    = 1'b1;
        burst.tail_packed = FFFD_PACKED;
        burst.tail_len    = FFFD_LEN;
      end else begin
        hold_lead            = 1'b1;
        held_count_next      = 2'd1;
        expected_length_next = cls;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      expected_length <= 3'd0;
    end else if (take) begin
      held_count      <= held_count_next;
      expected_length <= expected_length_next;
    end
  end

  // held bytes need no reset, only entries below held_count are read
  always_ff @(posedge clk) begin
    if (take && hold_lead) begin
      held_bytes[0] <= byte_in;
    end else if (take && store_cont) begin
      case (held_count)
        2'd1:    held_bytes[1] <= byte_in;
        default: held_bytes[2] <= byte_in;
      endcase
    end
  end

endmodule

[hdl/u8cp_result_queue.sv]
module u8cp_result_queue
  import u8cp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  burst_t      burst,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] packed_bytes,
  output logic [2:0]  char_length,
  output logic        last_of_run
);

  logic [1:0]  fffd_cnt;
  logic        tail_vld;
  logic [31:0] tail_packed;
  logic [2:0]  tail_len;
  logic        busy;
  logic        final_one;

  assign busy      = (fffd_cnt != 2'd0) || tail_vld;
  assign final_one = (fffd_cnt == 2'd0) || (fffd_cnt == 2'd1 && !tail_vld);
  // the slot can be refilled in the cycle its last result leaves
  assign free      = !busy || (out_ready && final_one);

  assign out_valid    = busy;
  assign last_of_run  = final_one;
  assign packed_bytes = (fffd_cnt != 2'd0) ? FFFD_PACKED : tail_packed;
  assign char_length  = (fffd_cnt != 2'd0) ? FFFD_LEN : tail_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      fffd_cnt <= 2'd0;
      tail_vld <= 1'b0;
    end else if (load) begin
      fffd_cnt <= burst.fffd_cnt;
      tail_vld <= burst.tail_vld;
    end else if (busy && out_ready) begin
      if (fffd_cnt != 2'd0) begin
        fffd_cnt <= fffd_cnt - 2'd1;
      end else begin
        tail_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tail_packed <= burst.tail_packed;
      tail_len    <= burst.tail_len;
    end
  end

endmodule

[hdl/utf8_char_packer.sv]
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid / in_ready   | byte_in
// output   | out_valid / out_ready | packed_bytes, char_length, last_of_run
//
// one byte is taken per cycle while each byte gives at most one result and
// out_ready is high, and a result shows in the cycle after its byte is taken
// a broken sequence gives up to four results from the result register, one
// per cycle while out_ready is high; input waits while that register holds
// results not all leaving at this edge, even for a byte that gives no result
// reset (rst, synchronous) empties the result register and drops held bytes
module utf8_char_packer
  import u8cp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] packed_bytes,
  output logic [2:0]  char_length,
  output logic        last_of_run
);

  burst_t burst;
  logic   take;
  logic   free;
  logic   load;

  assign in_ready = free;
  assign take     = in_valid && in_ready;
  assign load     = take && ((burst.fffd_cnt != 2'd0) || burst.tail_vld);

  u8cp_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .byte_in (byte_in),
    .burst   (burst)
  );

  u8cp_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .burst        (burst),
    .free         (free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .packed_bytes (packed_bytes),
    .char_length  (char_length),
    .last_of_run  (last_of_run)
  );

endmodule

[hdl/u8cp_checker.sv]
`include "utf8_char_packer_macros.svh"

module u8cp_checker
  import u8cp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] packed_bytes,
  input logic [2:0]  char_length,
  input logic        last_of_run
);

  `U8CP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(packed_bytes) && $stable(char_length), "stalled result changed")
  `U8CP_ASSERT_NOW(a_idle_ready, !out_valid, in_ready, "input blocked with no result pending")
  `U8CP_ASSERT_NOW(a_term, out_valid && char_length == TERM_LEN,
    packed_bytes == 32'h0 && last_of_run, "bad terminator")
  `U8CP_ASSERT_NOW(a_ascii, out_valid && char_length == CLASS_ASCII,
    packed_bytes[31:7] == 25'h0, "bad single byte character")
  `U8CP_ASSERT_NOW(a_not_last, out_valid && !last_of_run,
    packed_bytes == FFFD_PACKED && char_length == FFFD_LEN, "early result not a replacement")

endmodule

bind utf8_char_packer u8cp_checker u_checker (.*);
